### hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BPSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define BPSQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hdl/bpsq_pkg.sv
// Package with the shared types and constants of the box proximity query block.
`default_nettype none
package bpsq_pkg;
  localparam int MAX_ENTRIES = 32;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int GAP_W = 16;
  localparam int BOX_W = 62;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // One command handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] entry_index;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [14:0] half_width;
    logic [14:0] half_height;
    logic [15:0] gap_limit;
  } cmd_t;
endpackage
`default_nettype wire

### hdl/bpsq_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module bpsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/bpsq_front.sv
// Front end: accepts input beats, drops ignored ones and queues commands.
`default_nettype none
`include "assert_macros.svh"
module bpsq_front import bpsq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cmd_t        in_cmd,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);
  cmd_t       fifo_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fifo_cnt;
  logic       keep;
  logic       push;
  logic       pop;

  // Unused kind codes and slots past the table end do nothing.
  always_comb begin
    keep = 1'b1;
    if (in_cmd.kind != KIND_LOAD && in_cmd.kind != KIND_CLEAR &&
        in_cmd.kind != KIND_QUERY) begin
      keep = 1'b0;
    end else if (in_cmd.kind != KIND_QUERY &&
                 {1'b0, in_cmd.entry_index} >= 6'(MAX_ENTRIES)) begin
      keep = 1'b0;
    end
  end

  assign in_ready  = (fifo_cnt != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (fifo_cnt != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo_mem[rd_ptr];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fifo_cnt <= fifo_cnt + 2'd1;
      end else if (pop && !push) begin
        fifo_cnt <= fifo_cnt - 2'd1;
      end
    end
  end

  `BPSQ_ASSERT(a_fifo_bound, fifo_cnt <= 2'd2, "command queue overflow")
  `BPSQ_ASSERT_NEXT(a_fifo_grow, push && !pop, fifo_cnt == $past(fifo_cnt) + 2'd1, "queue push lost")
endmodule
`default_nettype wire

### hdl/bpsq_back.sv
// Back end: box table, scan with gap compute, insertion sort and result output.
`default_nettype none
`include "assert_macros.svh"
module bpsq_back import bpsq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_t        cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       match_index,
  output logic [GAP_W-1:0] match_gap,
  output logic             found,
  output logic             last
);
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t                  state;
  logic [MAX_ENTRIES-1:0]  box_valid;
  logic [ADDR_W-1:0]       scan_addr;
  cmd_t                    query;
  logic                    ram_we;
  logic [BOX_W-1:0]        ram_rdata;
  logic                    s1_vld;
  logic                    s1_ev;
  logic [ADDR_W-1:0]       s1_idx;
  logic                    s2_hit;
  logic [GAP_W-1:0]        s2_gap;
  logic [ADDR_W-1:0]       s2_idx;
  logic [GAP_W-1:0]        hit_gap [MAX_ENTRIES];
  logic [ADDR_W-1:0]       hit_idx [MAX_ENTRIES];
  logic [GAP_W-1:0]        hit_gap_next [MAX_ENTRIES];
  logic [ADDR_W-1:0]       hit_idx_next [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  ge;
  logic [CNT_W-1:0]        hit_cnt;
  logic                    slot_free;
  logic                    accept;
  logic signed [16:0]      dx;
  logic signed [16:0]      dy;
  logic [16:0]             ax;
  logic [16:0]             ay;
  logic signed [17:0]      gx;
  logic signed [17:0]      gy;
  logic signed [17:0]      gmax;
  logic [GAP_W-1:0]        gap;

  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign ram_we    = accept && cmd.kind == KIND_LOAD;
  assign slot_free = !out_valid || out_ready;

  bpsq_ram #(.WIDTH(BOX_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(cmd.entry_index)),
    .wdata ({cmd.centre_x, cmd.centre_y, cmd.half_width, cmd.half_height}),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  // Per-axis gaps against the entry read last cycle, larger one clamped at zero.
  always_comb begin
    dx = 17'(signed'(query.centre_x)) - 17'(signed'(ram_rdata[61:46]));
    dy = 17'(signed'(query.centre_y)) - 17'(signed'(ram_rdata[45:30]));
    ax = dx[16] ? 17'(-dx) : 17'(dx);
    ay = dy[16] ? 17'(-dy) : 17'(dy);
    gx = signed'({1'b0, ax}) - signed'(18'(query.half_width)) - signed'(18'(ram_rdata[29:15]));
    gy = signed'({1'b0, ay}) - signed'(18'(query.half_height)) - signed'(18'(ram_rdata[14:0]));
    gmax = (gx < gy) ? gy : gx;
    gap = gmax[17] ? '0 : gmax[GAP_W-1:0];
  end

  // Stable descending insertion: the new hit goes after all gaps not below it.
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      ge[k] = (CNT_W'(k) < hit_cnt) && (hit_gap[k] >= s2_gap);
    end
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (ge[k]) begin
        hit_gap_next[k] = hit_gap[k];
        hit_idx_next[k] = hit_idx[k];
      end else if (k == 0 || ge[(k == 0) ? 0 : k - 1]) begin
        hit_gap_next[k] = s2_gap;
        hit_idx_next[k] = s2_idx;
      end else begin
        hit_gap_next[k] = hit_gap[(k == 0) ? 0 : k - 1];
        hit_idx_next[k] = hit_idx[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Scan pipeline and sorted list payload.
  always_ff @(posedge clk) begin
    s1_idx <= scan_addr;
    s1_ev  <= box_valid[scan_addr];
    s2_gap <= gap;
    s2_idx <= s1_idx;
    if (s2_hit) begin
      hit_gap <= hit_gap_next;
      hit_idx <= hit_idx_next;
    end else if (state == ST_EMIT && slot_free) begin
      for (int k = 0; k < MAX_ENTRIES - 1; k++) begin
        hit_gap[k] <= hit_gap[k + 1];
        hit_idx[k] <= hit_idx[k + 1];
      end
    end
    if (accept && cmd.kind == KIND_QUERY) begin
      query <= cmd;
    end
  end

  // Control: table valid bits, sequencer, hit count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      box_valid <= '0;
      scan_addr <= '0;
      s1_vld    <= 1'b0;
      s2_hit    <= 1'b0;
      hit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      s1_vld <= (state == ST_SCAN);
      s2_hit <= s1_vld && s1_ev && ({1'b0, gap} < {1'b0, query.gap_limit});
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd.kind)
              KIND_LOAD:  box_valid[ADDR_W'(cmd.entry_index)] <= 1'b1;
              KIND_CLEAR: box_valid[ADDR_W'(cmd.entry_index)] <= 1'b0;
              KIND_QUERY: begin
                scan_addr <= '0;
                hit_cnt   <= '0;
                state     <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + ADDR_W'(1);
          if (scan_addr == ADDR_W'(MAX_ENTRIES - 1)) begin
            state <= ST_DRAIN;
          end
          if (s2_hit) begin
            hit_cnt <= hit_cnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (s2_hit) begin
            hit_cnt <= hit_cnt + CNT_W'(1);
          end else if (!s1_vld) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (hit_cnt == '0) begin
              match_index <= '0;
              match_gap   <= '0;
              found       <= 1'b0;
              last        <= 1'b1;
              state       <= ST_IDLE;
            end else begin
              match_index <= 5'(hit_idx[0]);
              match_gap   <= hit_gap[0];
              found       <= 1'b1;
              last        <= (hit_cnt == CNT_W'(1));
              hit_cnt     <= hit_cnt - CNT_W'(1);
              if (hit_cnt == CNT_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BPSQ_ASSERT(a_empty_is_last, !out_valid || found || last, "empty result without last")
  `BPSQ_ASSERT(a_cnt_bound, hit_cnt <= CNT_W'(MAX_ENTRIES), "hit count past table size")
endmodule
`default_nettype wire

### hdl/box_proximity_sorted_query.sv
// Load and clear take effect in the cycle after the back end accepts them while idle.
// A query scans all 32 entries, one per cycle; its first result leaves after the scan and
// the pipeline drain, then one beat per cycle while the receiver is ready.
// The back end takes no new command until a query has scanned, drained and emitted its results.
// A two-entry command queue lets input beats be taken while a query is in progress.
// Reset (rst, synchronous) clears all valid marks, the queue and the output register.
`default_nettype none
module box_proximity_sorted_query import bpsq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic [4:0]         entry_index,
  input  wire logic signed [15:0] centre_x,
  input  wire logic signed [15:0] centre_y,
  input  wire logic [14:0]        half_width,
  input  wire logic [14:0]        half_height,
  input  wire logic [15:0]        gap_limit,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              match_index,
  output logic [15:0]             match_gap,
  output logic                    found,
  output logic                    last
);
  cmd_t in_cmd;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Pack the input beat into one command.
  always_comb begin
    in_cmd.kind        = kind;
    in_cmd.entry_index = entry_index;
    in_cmd.centre_x    = centre_x;
    in_cmd.centre_y    = centre_y;
    in_cmd.half_width  = half_width;
    in_cmd.half_height = half_height;
    in_cmd.gap_limit   = gap_limit;
  end

  bpsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bpsq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_index (match_index),
    .match_gap   (match_gap),
    .found       (found),
    .last        (last)
  );
endmodule
`default_nettype wire
